// ===== hw/rtl/raid5_stripe_parity_store_unit_assert.svh =====
// Assertion macros shared by the RAID-5 parity store RTL.
`ifndef RAID5_STRIPE_PARITY_STORE_UNIT_ASSERT_SVH
`define RAID5_STRIPE_PARITY_STORE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// A property checked on every rising clk edge outside of reset.
`define R5SPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// An overlapping implication checked on every rising clk edge outside of reset.
`define R5SPS_ASSERT_IMP(label, ante, cons, msg) \
    `R5SPS_ASSERT(label, (ante) |-> (cons), msg)
`else
`define R5SPS_ASSERT(label, prop, msg)
`define R5SPS_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/r5sps_pkg.sv =====
// Shared types, codes and the microprogram of the RAID-5 parity store.
package r5sps_pkg;

    localparam int DATA_W     = 8;
    localparam int DISK_W     = 3;
    localparam int STRIPE_W   = 2;
    localparam int BLOCK_W    = 2;
    localparam int OFFSET_W   = 4;
    localparam int TDATA_W    = 24;
    localparam int IN_USER_W  = 1;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int STEP_W     = 4;

    localparam logic [DATA_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [DATA_W-1:0] SPACE_CHAR   = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_FAILED_DISK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGRADED    = 1'd1;

    // Wait modes of a step.
    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_IN   = 2'd1;
    localparam logic [1:0] WAIT_OUT  = 2'd2;

    // Jump conditions.
    localparam logic [2:0] JC_NEXT      = 3'd0;
    localparam logic [2:0] JC_ALWAYS    = 3'd1;
    localparam logic [2:0] JC_IS_READ   = 3'd2;
    localparam logic [2:0] JC_FULL      = 3'd3;
    localparam logic [2:0] JC_BAD       = 3'd4;
    localparam logic [2:0] JC_REBUILD   = 3'd5;
    localparam logic [2:0] JC_LOOP_MORE = 3'd6;
    localparam logic [2:0] JC_CLR_MORE  = 3'd7;

    // Memory address sources.
    localparam logic [2:0] AS_CLR  = 3'd0;
    localparam logic [2:0] AS_PAR  = 3'd1;
    localparam logic [2:0] AS_DATA = 3'd2;
    localparam logic [2:0] AS_RD   = 3'd3;
    localparam logic [2:0] AS_LOOP = 3'd4;

    // Memory write data sources.
    localparam logic [1:0] WS_ZERO = 2'd0;
    localparam logic [1:0] WS_PARX = 2'd1;
    localparam logic [1:0] WS_DATA = 2'd2;

    // Accumulator operations.
    localparam logic [1:0] AC_HOLD = 2'd0;
    localparam logic [1:0] AC_CLR  = 2'd1;
    localparam logic [1:0] AC_LOAD = 2'd2;
    localparam logic [1:0] AC_XORP = 2'd3;

    // Rebuild loop counter operations.
    localparam logic [1:0] LP_HOLD = 2'd0;
    localparam logic [1:0] LP_CLR  = 2'd1;
    localparam logic [1:0] LP_INC  = 2'd2;

    // Result kinds.
    localparam logic [2:0] EMIT_NONE    = 3'd0;
    localparam logic [2:0] EMIT_WRITE   = 3'd1;
    localparam logic [2:0] EMIT_REFUSE  = 3'd2;
    localparam logic [2:0] EMIT_READ    = 3'd3;
    localparam logic [2:0] EMIT_REBUILT = 3'd4;
    localparam logic [2:0] EMIT_BAD     = 3'd5;

    // Microprogram step addresses.
    localparam logic [STEP_W-1:0] ST_CLR   = 4'd0;
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd1;
    localparam logic [STEP_W-1:0] ST_WR0   = 4'd2;
    localparam logic [STEP_W-1:0] ST_WR1   = 4'd3;
    localparam logic [STEP_W-1:0] ST_WR2   = 4'd4;
    localparam logic [STEP_W-1:0] ST_WFULL = 4'd5;
    localparam logic [STEP_W-1:0] ST_RD0   = 4'd6;
    localparam logic [STEP_W-1:0] ST_RD1   = 4'd7;
    localparam logic [STEP_W-1:0] ST_RD2   = 4'd8;
    localparam logic [STEP_W-1:0] ST_RL    = 4'd9;
    localparam logic [STEP_W-1:0] ST_RF    = 4'd10;
    localparam logic [STEP_W-1:0] ST_RBAD  = 4'd11;

    typedef struct packed {
        logic [1:0]        wait_mode;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic [2:0]        addr_sel;
        logic              rd_en;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic [1:0]        acc_op;
        logic [1:0]        loop_op;
        logic              wcnt_inc;
        logic              clr_inc;
        logic [2:0]        emit;
    } ctrl_t;

    typedef struct packed {
        logic is_read;
        logic full;
        logic bad;
        logic rebuild;
        logic loop_more;
        logic clr_more;
    } cond_t;

    typedef struct packed {
        logic                func;
        logic [DATA_W-1:0]   data_byte;
        logic [DISK_W-1:0]   disk;
        logic [STRIPE_W-1:0] stripe;
        logic [BLOCK_W-1:0]  block;
        logic [OFFSET_W-1:0] offset;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   result_byte;
        logic [DISK_W-1:0]   where_disk;
        logic [STRIPE_W-1:0] where_stripe;
        logic [BLOCK_W-1:0]  where_block;
        logic [OFFSET_W-1:0] where_offset;
        logic                accepted;
        logic                rebuilt;
    } result_t;

    localparam ctrl_t CTRL_NOP = '0;

    // Control store: one control word per step.
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        case (step)
            ST_CLR:
            begin
                w.addr_sel = AS_CLR;
                w.wr_en    = 1'b1;
                w.wr_sel   = WS_ZERO;
                w.clr_inc  = 1'b1;
                w.cond     = JC_CLR_MORE;
                w.target   = ST_CLR;
            end
            ST_IDLE:
            begin
                w.wait_mode = WAIT_IN;
                w.cond      = JC_IS_READ;
                w.target    = ST_RD0;
            end
            ST_WR0:
            begin
                w.addr_sel = AS_PAR;
                w.rd_en    = 1'b1;
                w.cond     = JC_FULL;
                w.target   = ST_WFULL;
            end
            ST_WR1:
            begin
                w.addr_sel = AS_PAR;
                w.wr_en    = 1'b1;
                w.wr_sel   = WS_PARX;
            end
            ST_WR2:
            begin
                w.wait_mode = WAIT_OUT;
                w.addr_sel  = AS_DATA;
                w.wr_en     = 1'b1;
                w.wr_sel    = WS_DATA;
                w.wcnt_inc  = 1'b1;
                w.emit      = EMIT_WRITE;
                w.cond      = JC_ALWAYS;
                w.target    = ST_IDLE;
            end
            ST_WFULL:
            begin
                w.wait_mode = WAIT_OUT;
                w.emit      = EMIT_REFUSE;
                w.cond      = JC_ALWAYS;
                w.target    = ST_IDLE;
            end
            ST_RD0:
            begin
                w.acc_op  = AC_CLR;
                w.loop_op = LP_CLR;
                w.cond    = JC_BAD;
                w.target  = ST_RBAD;
            end
            ST_RD1:
            begin
                w.addr_sel = AS_RD;
                w.rd_en    = 1'b1;
                w.cond     = JC_REBUILD;
                w.target   = ST_RL;
            end
            ST_RD2:
            begin
                w.wait_mode = WAIT_OUT;
                w.acc_op    = AC_LOAD;
                w.emit      = EMIT_READ;
                w.cond      = JC_ALWAYS;
                w.target    = ST_IDLE;
            end
            ST_RL:
            begin
                w.addr_sel = AS_LOOP;
                w.rd_en    = 1'b1;
                w.acc_op   = AC_XORP;
                w.loop_op  = LP_INC;
                w.cond     = JC_LOOP_MORE;
                w.target   = ST_RL;
            end
            ST_RF:
            begin
                w.wait_mode = WAIT_OUT;
                w.acc_op    = AC_XORP;
                w.emit      = EMIT_REBUILT;
                w.cond      = JC_ALWAYS;
                w.target    = ST_IDLE;
            end
            ST_RBAD:
            begin
                w.wait_mode = WAIT_OUT;
                w.emit      = EMIT_BAD;
                w.cond      = JC_ALWAYS;
                w.target    = ST_IDLE;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/r5sps_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and jump logic.
module r5sps_seq
    import r5sps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cond_t flags,
    input  logic  in_valid,
    input  logic  out_free,
    output ctrl_t ctrl,
    output logic  go
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              cond_true;

    assign ctrl = ucode_rom(step_reg);

    // A step that waits on a handshake holds until that side is ready.
    always_comb
    begin
        case (ctrl.wait_mode)
            WAIT_IN:  go = in_valid;
            WAIT_OUT: go = out_free;
            default:  go = 1'b1;
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            JC_ALWAYS:    cond_true = 1'b1;
            JC_IS_READ:   cond_true = flags.is_read;
            JC_FULL:      cond_true = flags.full;
            JC_BAD:       cond_true = flags.bad;
            JC_REBUILD:   cond_true = flags.rebuild;
            JC_LOOP_MORE: cond_true = flags.loop_more;
            JC_CLR_MORE:  cond_true = flags.clr_more;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!go)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hw/rtl/r5sps_dp.sv =====
// Datapath: byte store memory, write slot counters, XOR accumulator and result register.
module r5sps_dp
    import r5sps_pkg::*;
#(
    parameter int DISKS       = 5,
    parameter int STRIPES     = 3,
    parameter int BLOCKS      = 4,
    parameter int BLOCK_BYTES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    input  logic              go,
    input  logic              item_load,
    input  item_t             item_in,
    input  logic [DISK_W-1:0] failed_disk,
    input  logic              degraded,
    output cond_t             flags,
    output result_t           result
);

    localparam int STORE      = DISKS * STRIPES * BLOCKS * BLOCK_BYTES;
    localparam int DATA_BYTES = STRIPES * (DISKS - 1) * BLOCKS * BLOCK_BYTES;
    localparam int AW         = $clog2(STORE);
    localparam int DW         = $clog2(DISKS);
    localparam int PW         = $clog2(DISKS - 1);
    localparam int SW         = $clog2(STRIPES + 1);
    localparam int BW         = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int OW         = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int CW         = $clog2(DATA_BYTES + 1);

    logic [DATA_W-1:0] store_mem [STORE];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] wbyte;
    logic [AW-1:0]     mem_addr;
    item_t             item_reg;
    result_t           result_reg;

    logic [OW-1:0] wo_reg;
    logic [OW-1:0] wo_next;
    logic [BW-1:0] wb_reg;
    logic [BW-1:0] wb_next;
    logic [PW-1:0] wdpos_reg;
    logic [PW-1:0] wdpos_next;
    logic [SW-1:0] ws_reg;
    logic [SW-1:0] ws_next;
    logic [DW-1:0] pd_reg;
    logic [DW-1:0] pd_next;
    logic [CW-1:0] wcnt_reg;
    logic [CW-1:0] wcnt_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic [DW-1:0] x_reg;
    logic [DW-1:0] x_next;
    logic          pend_reg;
    logic          pend_next;
    logic [DW-1:0] wd;

    function automatic logic [AW-1:0] slot(input int d, input int s, input int b, input int o);
        return AW'(((d * STRIPES + s) * BLOCKS + b) * BLOCK_BYTES + o);
    endfunction

    // Data disk of the next write: the parity disk is skipped.
    assign wd    = (DW'(wdpos_reg) < pd_reg) ? DW'(wdpos_reg) : DW'(wdpos_reg) + DW'(1);
    assign wbyte = (item_reg.data_byte == NEWLINE_CHAR) ? SPACE_CHAR : item_reg.data_byte;

    assign flags.is_read   = item_in.func;
    assign flags.full      = (wcnt_reg == CW'(DATA_BYTES));
    assign flags.bad       = (int'(item_reg.disk) >= DISKS) || (int'(item_reg.stripe) >= STRIPES)
                             || (int'(item_reg.block) >= BLOCKS)
                             || (int'(item_reg.offset) >= BLOCK_BYTES);
    assign flags.rebuild   = degraded && (item_reg.disk == failed_disk);
    assign flags.loop_more = (x_reg != DW'(DISKS - 1));
    assign flags.clr_more  = (clr_reg != AW'(STORE - 1));

    always_comb
    begin
        case (ctrl.addr_sel)
            AS_PAR:  mem_addr = slot(int'(pd_reg), int'(ws_reg), int'(wb_reg), int'(wo_reg));
            AS_DATA: mem_addr = slot(int'(wd), int'(ws_reg), int'(wb_reg), int'(wo_reg));
            AS_RD:   mem_addr = slot(int'(item_reg.disk), int'(item_reg.stripe),
                                     int'(item_reg.block), int'(item_reg.offset));
            AS_LOOP: mem_addr = slot(int'(x_reg), int'(item_reg.stripe),
                                     int'(item_reg.block), int'(item_reg.offset));
            default: mem_addr = clr_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.wr_sel)
            WS_PARX: wr_data = rdata_reg ^ wbyte;
            WS_DATA: wr_data = wbyte;
            default: wr_data = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.acc_op)
            AC_CLR:  acc_next = '0;
            AC_LOAD: acc_next = rdata_reg;
            AC_XORP: acc_next = pend_reg ? (acc_reg ^ rdata_reg) : acc_reg;
            default: acc_next = acc_reg;
        endcase
    end

    // Write slot counters advance in row order: offset, block, data disk, stripe.
    always_comb
    begin
        wo_next    = wo_reg;
        wb_next    = wb_reg;
        wdpos_next = wdpos_reg;
        ws_next    = ws_reg;
        pd_next    = pd_reg;
        wcnt_next  = wcnt_reg;
        if (go && ctrl.wcnt_inc)
        begin
            wcnt_next = wcnt_reg + CW'(1);
            if (wo_reg != OW'(BLOCK_BYTES - 1))
            begin
                wo_next = wo_reg + OW'(1);
            end
            else
            begin
                wo_next = '0;
                if (wb_reg != BW'(BLOCKS - 1))
                begin
                    wb_next = wb_reg + BW'(1);
                end
                else
                begin
                    wb_next = '0;
                    if (wdpos_reg != PW'(DISKS - 2))
                    begin
                        wdpos_next = wdpos_reg + PW'(1);
                    end
                    else
                    begin
                        wdpos_next = '0;
                        ws_next    = ws_reg + SW'(1);
                        pd_next    = (pd_reg == DW'(DISKS - 1)) ? '0 : pd_reg + DW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        x_next    = x_reg;
        pend_next = pend_reg;
        if (go)
        begin
            case (ctrl.loop_op)
                LP_CLR:
                begin
                    x_next    = '0;
                    pend_next = 1'b0;
                end
                LP_INC:
                begin
                    x_next    = x_reg + DW'(1);
                    pend_next = (int'(x_reg) != int'(item_reg.disk));
                end
                default:
                begin
                    x_next    = x_reg;
                    pend_next = pend_reg;
                end
            endcase
        end
    end

    assign clr_next = (go && ctrl.clr_inc) ? clr_reg + AW'(1) : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wo_reg    <= '0;
            wb_reg    <= '0;
            wdpos_reg <= '0;
            ws_reg    <= '0;
            pd_reg    <= '0;
            wcnt_reg  <= '0;
            clr_reg   <= '0;
            x_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            wo_reg    <= wo_next;
            wb_reg    <= wb_next;
            wdpos_reg <= wdpos_next;
            ws_reg    <= ws_next;
            pd_reg    <= pd_next;
            wcnt_reg  <= wcnt_next;
            clr_reg   <= clr_next;
            x_reg     <= x_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && ctrl.wr_en)
        begin
            store_mem[mem_addr] <= wr_data;
        end
        if (go && ctrl.rd_en)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= item_in;
        end
        if (go)
        begin
            acc_reg <= acc_next;
        end
        if (go)
        begin
            case (ctrl.emit)
                EMIT_WRITE:
                begin
                    result_reg.result_byte  <= wbyte;
                    result_reg.where_disk   <= DISK_W'(wd);
                    result_reg.where_stripe <= STRIPE_W'(ws_reg);
                    result_reg.where_block  <= BLOCK_W'(wb_reg);
                    result_reg.where_offset <= OFFSET_W'(wo_reg);
                    result_reg.accepted     <= 1'b1;
                    result_reg.rebuilt      <= 1'b0;
                end
                EMIT_REFUSE:
                begin
                    result_reg <= '0;
                end
                EMIT_READ, EMIT_REBUILT:
                begin
                    result_reg.result_byte  <= acc_next;
                    result_reg.where_disk   <= item_reg.disk;
                    result_reg.where_stripe <= item_reg.stripe;
                    result_reg.where_block  <= item_reg.block;
                    result_reg.where_offset <= item_reg.offset;
                    result_reg.accepted     <= 1'b1;
                    result_reg.rebuilt      <= (ctrl.emit == EMIT_REBUILT);
                end
                EMIT_BAD:
                begin
                    result_reg.result_byte  <= '0;
                    result_reg.where_disk   <= item_reg.disk;
                    result_reg.where_stripe <= item_reg.stripe;
                    result_reg.where_block  <= item_reg.block;
                    result_reg.where_offset <= item_reg.offset;
                    result_reg.accepted     <= 1'b0;
                    result_reg.rebuilt      <= 1'b0;
                end
                default:
                begin
                    result_reg <= result_reg;
                end
            endcase
        end
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/raid5_stripe_parity_store_unit.sv =====
// Top level of the RAID-5 byte store with rotating XOR parity.
// Write word: parity read, parity write and data write between acceptance and the next ready.
// Refused write and out-of-range read: no store write. Plain read: one memory read.
// Rebuilt read: the single memory read port is stepped across every disk.
// After reset a clearing pass over all DISKS*STRIPES*BLOCKS*BLOCK_BYTES bytes (960 by default)
// zeroes the store with s_axis_tready low; configuration writes are taken during it.
`include "raid5_stripe_parity_store_unit_assert.svh"

module raid5_stripe_parity_store_unit
    import r5sps_pkg::*;
#(
    parameter int DISKS       = 5,
    parameter int STRIPES     = 3,
    parameter int BLOCKS      = 4,
    parameter int BLOCK_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input word channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_byte[7:0], disk[10:8], stripe[12:11], block[14:13], offset[18:15], zero fill
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    // func[0]: 0 write next data byte, 1 read a stored byte
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // Result word channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_byte[7:0], where_disk[10:8], where_stripe[12:11], where_block[14:13],
    // where_offset[18:15], zero fill
    output logic [TDATA_W-1:0]    m_axis_tdata,
    // accepted[0], rebuilt[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_t             ctrl;
    cond_t             flags;
    result_t           result;
    item_t             item_in;
    logic              go;
    logic              out_free;
    logic              in_fire;
    logic              emit_fire;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [DISK_W-1:0] failed_disk_reg;
    logic              degraded_reg;

    // Unpack the input word into its fields.
    assign item_in.func      = s_axis_tuser[0];
    assign item_in.data_byte = s_axis_tdata[7:0];
    assign item_in.disk      = s_axis_tdata[10:8];
    assign item_in.stripe    = s_axis_tdata[12:11];
    assign item_in.block     = s_axis_tdata[14:13];
    assign item_in.offset    = s_axis_tdata[18:15];

    // The sequencer takes a word only in its idle step; the output register
    // lets it do so while an earlier result still waits downstream.
    assign s_axis_tready = (ctrl.wait_mode == WAIT_IN);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign emit_fire     = go && (ctrl.emit != EMIT_NONE);

    r5sps_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .go       (go)
    );

    r5sps_dp
    #(
        .DISKS       (DISKS),
        .STRIPES     (STRIPES),
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .go          (go),
        .item_load   (in_fire),
        .item_in     (item_in),
        .failed_disk (failed_disk_reg),
        .degraded    (degraded_reg),
        .flags       (flags),
        .result      (result)
    );

    // The result word stays valid until the consumer takes it.
    always_comb
    begin
        if (emit_fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg    <= 1'b0;
            failed_disk_reg <= '0;
            degraded_reg    <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_FAILED_DISK: failed_disk_reg <= cfg_wdata[DISK_W-1:0];
                    REG_DEGRADED:    degraded_reg    <= cfg_wdata[0];
                    default:         degraded_reg    <= degraded_reg;
                endcase
            end
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {5'b0, result.where_offset, result.where_block,
                            result.where_stripe, result.where_disk, result.result_byte};
    assign m_axis_tuser  = {result.rebuilt, result.accepted};

    // A result is only produced when the output register is free to take it.
    `R5SPS_ASSERT_IMP(a_emit_room, emit_fire, !m_tvalid_reg || m_axis_tready, "result overwrote a pending word")
    // One word is worked on at a time: ready drops right after an acceptance.
    `R5SPS_ASSERT(a_one_at_a_time, in_fire |=> !s_axis_tready, "second word taken while busy")
    // The output becomes valid only as the microprogram issues a result.
    `R5SPS_ASSERT(a_valid_source, $rose(m_tvalid_reg) |-> $past(emit_fire), "result valid without emit")

endmodule
